// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned DataW       = 32;
  localparam int unsigned CountW      = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_REPORT
  } state_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] payload;
  } cell_cmd_t;

endpackage

// ===== rtl/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels carrying queue requests and results.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] key;
  logic        [31:0] payload;

  modport source (output valid, kind, key, payload, input ready);
  modport sink   (input valid, kind, key, payload, output ready);
endinterface

interface spq_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic        [4:0]  removed_count;
  logic        [4:0]  fill_count;
  logic               head_valid;
  logic signed [31:0] head_key;
  logic        [31:0] head_payload;

  modport source (output valid, status, removed_count, fill_count, head_valid, head_key,
                  head_payload, input ready);
  modport sink   (input valid, status, removed_count, fill_count, head_valid, head_key,
                  head_payload, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a key, a data word and a used bit.
// Shifts right on insert, left on a single-entry remove step.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_cmd_t        cmd_i,
  input  logic             left_flag_i,
  input  logic             left_used_i,
  input  logic [KeyW-1:0]  left_key_i,
  input  logic [DataW-1:0] left_payload_i,
  input  logic             right_used_i,
  input  logic [KeyW-1:0]  right_key_i,
  input  logic [DataW-1:0] right_payload_i,
  output logic             used_o,
  output logic [KeyW-1:0]  key_o,
  output logic [DataW-1:0] payload_o,
  output logic             flag_o,
  output logic             match_o
);

  logic             used_q, used_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [DataW-1:0] payload_q, payload_d;
  logic             flag;

  // flag: this slot is at or past the point where cmd key belongs
  assign flag    = !(used_q && ($signed(key_q) > $signed(cmd_i.key)));
  assign match_o = used_q && (key_q == cmd_i.key);
  assign flag_o  = flag;
  assign used_o  = used_q;
  assign key_o   = key_q;
  assign payload_o = payload_q;

  always_comb begin
    used_d    = used_q;
    key_d     = key_q;
    payload_d = payload_q;
    if (cmd_i.ins && flag) begin
      if (left_flag_i) begin
        used_d    = used_q | left_used_i;
        key_d     = left_key_i;
        payload_d = left_payload_i;
      end else begin
        used_d    = 1'b1;
        key_d     = cmd_i.key;
        payload_d = cmd_i.payload;
      end
    end else if (cmd_i.rem && flag) begin
      used_d    = right_used_i;
      key_d     = right_key_i;
      payload_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Insert: the report state loads the result into the output register; no new request is
//   accepted until it loads. Remove: one matching entry leaves the cell chain per cycle,
//   then the report state loads the result; next request accepted the cycle after it loads.
// The output register lets a new request in while the previous result waits.
// Reset (async, active low) empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in a chain of cells sorted by descending key.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e           state_q, state_d;
  status_e          status_q, status_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [KeyW-1:0]  key_q, key_d;

  logic             ovalid_q, ovalid_d;
  status_e          ostatus_q, ostatus_d;
  logic [CountW-1:0] orem_q, orem_d, ofill_q, ofill_d;
  logic             ohv_q, ohv_d;
  logic [KeyW-1:0]  okey_q, okey_d;
  logic [DataW-1:0] opay_q, opay_d;

  logic [CAPACITY-1:0] used, flag, match;
  logic [KeyW-1:0]     keys [CAPACITY];
  logic [DataW-1:0]    pays [CAPACITY];

  cell_cmd_t cmd;
  logic      accept, full, any_match, out_free;
  logic [CW+CountW-1:0] fill_ext, cnt_ext;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (fill_q == CW'(CAPACITY));
  assign any_match  = |match;
  assign out_free   = !ovalid_q || out_o.ready;
  assign fill_ext   = {{CountW{1'b0}}, fill_q};
  assign cnt_ext    = {{CountW{1'b0}}, cnt_q};

  always_comb begin
    cmd.ins     = accept && (in_i.kind == OP_INSERT) && !full;
    cmd.rem     = (state_q == S_REMOVE) && any_match;
    cmd.key     = (state_q == S_REMOVE) ? key_q : in_i.key;
    cmd.payload = in_i.payload;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             lf, lu, ru;
    logic [KeyW-1:0]  lk, rk;
    logic [DataW-1:0] lp, rp;
    if (i == 0) begin : g_first
      assign lf = 1'b0;
      assign lu = 1'b1;
      assign lk = '0;
      assign lp = '0;
    end else begin : g_mid
      assign lf = flag[i-1];
      assign lu = used[i-1];
      assign lk = keys[i-1];
      assign lp = pays[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign ru = 1'b0;
      assign rk = '0;
      assign rp = '0;
    end else begin : g_inner
      assign ru = used[i+1];
      assign rk = keys[i+1];
      assign rp = pays[i+1];
    end
    spq_cell u_cell (
      .clk_i,
      .rst_ni,
      .cmd_i          (cmd),
      .left_flag_i    (lf),
      .left_used_i    (lu),
      .left_key_i     (lk),
      .left_payload_i (lp),
      .right_used_i   (ru),
      .right_key_i    (rk),
      .right_payload_i(rp),
      .used_o         (used[i]),
      .key_o          (keys[i]),
      .payload_o      (pays[i]),
      .flag_o         (flag[i]),
      .match_o        (match[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    ostatus_d = ostatus_q;
    orem_d    = orem_q;
    ofill_d   = ofill_q;
    ohv_d     = ohv_q;
    okey_d    = okey_q;
    opay_d    = opay_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          key_d = in_i.key;
          if (in_i.kind == OP_INSERT) begin
            state_d  = S_REPORT;
            status_d = full ? ST_FULL : ST_OK;
            fill_d   = full ? fill_q : fill_q + CW'(1);
          end else begin
            state_d = S_REMOVE;
          end
        end
      end
      S_REMOVE: begin
        if (any_match) begin
          cnt_d  = cnt_q + CW'(1);
          fill_d = fill_q - CW'(1);
        end else begin
          state_d = S_REPORT;
          if (cnt_q != '0) begin
            status_d = ST_OK;
          end else if (fill_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
      end
      S_REPORT: begin
        if (out_free) begin
          state_d   = S_IDLE;
          ovalid_d  = 1'b1;
          ostatus_d = status_q;
          orem_d    = cnt_ext[CountW-1:0];
          ofill_d   = fill_ext[CountW-1:0];
          ohv_d     = used[0];
          okey_d    = used[0] ? keys[0] : '0;
          opay_d    = used[0] ? pays[0] : '0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
      fill_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    ostatus_q <= ostatus_d;
    orem_q    <= orem_d;
    ofill_q   <= ofill_d;
    ohv_q     <= ohv_d;
    okey_q    <= okey_d;
    opay_q    <= opay_d;
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.status        = ostatus_q;
  assign out_o.removed_count = orem_q;
  assign out_o.fill_count    = ofill_q;
  assign out_o.head_valid    = ohv_q;
  assign out_o.head_key      = okey_q;
  assign out_o.head_payload  = opay_q;

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on queue results, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [4:0]  removed_count_i,
  input logic [4:0]  fill_count_i,
  input logic        head_valid_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before taken");

  a_head_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (head_valid_i == (fill_count_i != 5'd0)))
    else $error("head valid disagrees with fill count");

  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (removed_count_i != 5'd0) |-> (status_i == ST_OK))
    else $error("entries removed with error status");

  a_err_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> (removed_count_i == 5'd0))
    else $error("error status with nonzero removed count");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_EMPTY) |-> (fill_count_i == 5'd0) && !head_valid_i)
    else $error("empty status with entries held");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .removed_count_i (out_o.removed_count),
  .fill_count_i    (out_o.fill_count),
  .head_valid_i    (out_o.head_valid)
);
